// ----- rtl/core/led_pixel_color_corrector_macros.svh -----
// Assertion macros for the LED pixel color corrector.
`ifndef LED_PIXEL_COLOR_CORRECTOR_MACROS_SVH
`define LED_PIXEL_COLOR_CORRECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcc_pkg
// Shared types, constants and helpers of the LED pixel color corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcc_pkg;

   localparam int DEF_MAX_OUTPUTS = 512;
   localparam int DEF_MAX_FRAMES  = 8;
   localparam int DEF_MAX_LEDS    = 512;

   localparam int STEP_W     = 4;
   localparam int DIV_STEPS  = 12;   // dividend bits of the frame average
   localparam int PIPE_LAST  = 4;    // last step of the scale/gamma pipeline wait
   localparam int GAMMA_SIZE = 256;
   localparam logic [34:0] RECIP_100 = 35'd167773;   // ceil(2^24 / 100)

   typedef enum logic [1:0] {
      MODE_SET     = 2'd0,
      MODE_MAP     = 2'd1,
      MODE_GAMMA   = 2'd2,
      MODE_ADVANCE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_BLEND_FRAMES = 3'd0,
      CSR_BRIGHTNESS   = 3'd1,
      CSR_INTEN_RED    = 3'd2,
      CSR_INTEN_GREEN  = 3'd3,
      CSR_INTEN_BLUE   = 3'd4,
      CSR_FLOOR_RED    = 3'd5,
      CSR_FLOOR_GREEN  = 3'd6,
      CSR_FLOOR_BLUE   = 3'd7
   } csr_index_type;

   localparam logic [1:0] LUT_CH_INVALID = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_CHECK,
      S_HRD,
      S_HACC,
      S_DIVI,
      S_DIV,
      S_PIPE,
      S_PIX,
      S_FIN
   } ctl_state_type;

   typedef struct packed {
      logic              capture;
      logic              clear_en;
      logic              load_exec;
      logic              res_err;
      logic              res_led;
      logic              sum_clear;
      logic              hist_wr;
      logic              hist_acc;
      logic              div_start;
      logic              div_step;
      logic              res_pix;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      mode_type   mode;
      logic       map_ok;
      logic       blending;
      logic [3:0] n_frames;
      logic       clear_done;
   } status_type;

   // Truncating x / 100 for x below 2^17 by reciprocal multiply.
   function automatic logic [16:0] div100(input logic [16:0] x);
      logic [34:0] prod;
      prod = 35'(x) * RECIP_100;
      return 17'(prod >> 24);
   endfunction

   // Clamp a 17-bit value to 255.
   function automatic logic [7:0] sat8(input logic [16:0] x);
      return (x > 17'd255) ? 8'd255 : x[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/led_pixel_color_corrector.sv -----
// ----------------------------------------------------------------------------
// led_pixel_color_corrector
// Maps logical outputs to LEDs, blends frames, applies scale, gamma, floor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per item; mode selects set pixel, map load, gamma
//            load or frame advance. Every request returns exactly one rsp_*.
//   csr_*  : register writes (index 0..7), always ready; write only when idle.
// Sequence after acceptance:
//   loads and advance: decode, load, result; unmapped pixel: decode, check;
//   pixel without blending: check, scale/gamma pipeline, result;
//   pixel with blending over n frames: additionally the history
//   read loop (one memory port, one frame per loop pass) and the 12-step
//   averaging divider before the pipeline.
// One request is in flight at a time; the next is accepted while the
// previous result sits in the output register, even if not yet taken.
// A stalled receiver holds the result; the block then waits before loading
// the following result.
// Reset: a clearing pass over the map, history and gamma memories clears the
// map and history and loads identity gamma; req_ready stays low during it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pixel_color_corrector
   import lpcc_pkg::*;
#(
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
   parameter int MAX_LEDS    = DEF_MAX_LEDS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [8:0] req_output_index,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   input  wire logic       req_map_present,
   input  wire logic [8:0] req_map_led,
   input  wire logic [1:0] req_lut_channel,
   input  wire logic [7:0] req_lut_position,
   input  wire logic [7:0] req_lut_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_status,
   output logic [8:0]      rsp_led_number,
   output logic [7:0]      rsp_red_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_blue_out,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data
);

   cmd_type    cmd;
   status_type stat;

   // Register writes never stall
   assign csr_ready = 1'b1;

   lpcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpcc_datapath #(
      .MAX_OUTPUTS (MAX_OUTPUTS),
      .MAX_FRAMES  (MAX_FRAMES),
      .MAX_LEDS    (MAX_LEDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_output_index (req_output_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_map_present  (req_map_present),
      .req_map_led      (req_map_led),
      .req_lut_channel  (req_lut_channel),
      .req_lut_position (req_lut_position),
      .req_lut_value    (req_lut_value),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_led_number   (rsp_led_number),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out)
   );

endmodule

`default_nettype wire

// ----- rtl/core/lpcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpcc_ctrl
// Sequencer: clearing pass, decode, averaging loop, division steps, output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pixel_color_corrector_macros.svh"

module lpcc_ctrl
   import lpcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type stat,
   output cmd_type         cmd
);

   ctl_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // State, step counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.step  = step_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = (stat.mode == MODE_SET) ? S_CHECK : S_LOAD;
         end
         S_LOAD: begin
            cmd.load_exec = 1'b1;
            state_in      = S_FIN;
         end
         S_CHECK: begin
            step_in = '0;
            if (!stat.map_ok) begin
               cmd.res_err = 1'b1;
               state_in    = S_FIN;
            end else begin
               cmd.res_led = 1'b1;
               if (stat.blending) begin
                  cmd.hist_wr   = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = S_HRD;
               end else begin
                  state_in = S_PIPE;
               end
            end
         end
         S_HRD: begin
            state_in = S_HACC;
         end
         S_HACC: begin
            cmd.hist_acc = 1'b1;
            if (step_ff == stat.n_frames - 4'd1) begin
               step_in  = '0;
               state_in = S_DIVI;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_HRD;
            end
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_PIPE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_PIPE: begin
            if (step_ff == STEP_W'(PIPE_LAST)) begin
               step_in  = '0;
               state_in = S_PIX;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_PIX: begin
            cmd.res_pix = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   `LPCC_ASSERT_NOW(a_out_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "output overwritten while pending")
   `LPCC_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == S_DECODE, "accepted request not decoded")
   `LPCC_ASSERT_NOW(a_div_bound, clock, reset, state_ff == S_DIV, step_ff < STEP_W'(DIV_STEPS), "division step out of range")
   `LPCC_ASSERT_NOW(a_frame_bound, clock, reset, state_ff == S_HRD, step_ff < stat.n_frames && stat.blending, "frame read beyond blend count")

endmodule

`default_nettype wire

// ----- rtl/core/lpcc_datapath.sv -----
// ----------------------------------------------------------------------------
// lpcc_datapath
// Map, history and gamma memories, averaging divider, scale pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcc_datapath
   import lpcc_pkg::*;
#(
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
   parameter int MAX_LEDS    = DEF_MAX_LEDS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      stat,
   input  wire logic [1:0] req_mode,
   input  wire logic [8:0] req_output_index,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   input  wire logic       req_map_present,
   input  wire logic [8:0] req_map_led,
   input  wire logic [1:0] req_lut_channel,
   input  wire logic [7:0] req_lut_position,
   input  wire logic [7:0] req_lut_value,
   input  wire logic       csr_valid,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data,
   output logic            rsp_status,
   output logic [8:0]      rsp_led_number,
   output logic [7:0]      rsp_red_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_blue_out
);

   localparam int MAP_AW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int LED_W      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int FW         = $clog2(MAX_FRAMES);
   localparam int MAP_DEPTH  = 1 << MAP_AW;
   localparam int HIST_DEPTH = MAX_FRAMES << LED_W;
   localparam int HIST_AW    = FW + LED_W;
   localparam int CLR_A      = (HIST_DEPTH > MAP_DEPTH) ? HIST_DEPTH : MAP_DEPTH;
   localparam int CLR_LEN    = (CLR_A > GAMMA_SIZE) ? CLR_A : GAMMA_SIZE;
   localparam int CW         = $clog2(CLR_LEN);

   // Configuration registers
   logic [3:0] blend_ff;
   logic [6:0] bright_ff;
   logic [6:0] inten_ff [3];
   logic [6:0] floor_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff  <= 4'd0;
         bright_ff <= 7'd100;
         for (int c = 0; c < 3; c++) begin
            inten_ff[c] <= 7'd0;
            floor_ff[c] <= 7'd0;
         end
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BLEND_FRAMES: blend_ff    <= csr_data[3:0];
            CSR_BRIGHTNESS:   bright_ff   <= csr_data;
            CSR_INTEN_RED:    inten_ff[0] <= csr_data;
            CSR_INTEN_GREEN:  inten_ff[1] <= csr_data;
            CSR_INTEN_BLUE:   inten_ff[2] <= csr_data;
            CSR_FLOOR_RED:    floor_ff[0] <= csr_data;
            CSR_FLOOR_GREEN:  floor_ff[1] <= csr_data;
            CSR_FLOOR_BLUE:   floor_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Latched request
   mode_type   mode_ff;
   logic [8:0] idx_ff;
   logic [7:0] col_in_ff [3];
   logic       mpres_ff;
   logic [8:0] mled_ff;
   logic [1:0] lch_ff;
   logic [7:0] lpos_ff;
   logic [7:0] lval_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= mode_type'(req_mode);
         idx_ff       <= req_output_index;
         col_in_ff[0] <= req_red_in;
         col_in_ff[1] <= req_green_in;
         col_in_ff[2] <= req_blue_in;
         mpres_ff     <= req_map_present;
         mled_ff      <= req_map_led;
         lch_ff       <= req_lut_channel;
         lpos_ff      <= req_lut_position;
         lval_ff      <= req_lut_value;
      end
   end

   // Effective frame count and current slot
   logic [3:0]    n_frames;
   logic          blending;
   logic [FW-1:0] slot_ff, slot_in, cur_slot;
   logic [4:0]    slot_next;

   assign n_frames  = (32'(blend_ff) > MAX_FRAMES) ? 4'(MAX_FRAMES) : blend_ff;
   assign blending  = (n_frames >= 4'd2);
   assign cur_slot  = (5'(slot_ff) < 5'(n_frames)) ? slot_ff : '0;
   assign slot_next = 5'(cur_slot) + 5'd1;
   assign slot_in   = (slot_next >= 5'(n_frames)) ? '0 : FW'(slot_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.load_exec && mode_ff == MODE_ADVANCE && blending) begin
         slot_ff <= slot_in;
      end
   end

   // Clearing pass address
   logic [CW-1:0] clr_ff;
   logic          clear_done;

   assign clear_done = (clr_ff == CW'(CLR_LEN - 1));

   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
   end

   // Output map memory
   logic [9:0] map_mem [MAP_DEPTH];
   logic [9:0] map_rd_ff;
   logic       idx_ok;
   logic       map_ok;

   assign idx_ok = (32'(idx_ff) < MAX_OUTPUTS);
   assign map_ok = idx_ok && map_rd_ff[9] && (32'(map_rd_ff[8:0]) < MAX_LEDS);

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         if (32'(clr_ff) < MAP_DEPTH) map_mem[MAP_AW'(clr_ff)] <= 10'd0;
      end else if (cmd.load_exec && mode_ff == MODE_MAP && idx_ok) begin
         map_mem[MAP_AW'(idx_ff)] <= {mpres_ff, mled_ff};
      end
      map_rd_ff <= map_mem[MAP_AW'(idx_ff)];
   end

   // Result assembly registers
   logic       res_status_ff;
   logic [8:0] res_led_ff;
   logic [7:0] res_col_ff [3];
   logic [7:0] gam_rd_ff  [3];
   logic [7:0] lo_ff      [3];
   logic       load_bad;

   // Blend history memory
   logic [23:0]        hist_mem [HIST_DEPTH];
   logic [23:0]        hist_rd_ff;
   logic [HIST_AW-1:0] hist_wr_addr, hist_rd_addr;

   assign hist_wr_addr = {cur_slot, LED_W'(map_rd_ff[8:0])};
   assign hist_rd_addr = {FW'(cmd.step), LED_W'(res_led_ff)};

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         if (32'(clr_ff) < HIST_DEPTH) hist_mem[HIST_AW'(clr_ff)] <= 24'd0;
      end else if (cmd.hist_wr) begin
         hist_mem[hist_wr_addr] <= {col_in_ff[0], col_in_ff[1], col_in_ff[2]};
      end
      hist_rd_ff <= hist_mem[hist_rd_addr];
   end

   // Gamma memories, one per channel, identity after the clearing pass
   logic [7:0] gam_mem [3][GAMMA_SIZE];
   logic [7:0] b_ff    [3];

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.clear_en) begin
            if (32'(clr_ff) < GAMMA_SIZE) gam_mem[c][clr_ff[7:0]] <= clr_ff[7:0];
         end else if (cmd.load_exec && mode_ff == MODE_GAMMA && 32'(lch_ff) == c) begin
            gam_mem[c][lpos_ff] <= lval_ff;
         end
         gam_rd_ff[c] <= gam_mem[c][b_ff[c]];
      end
   end

   // Frame sums and averaging dividers, one bit per step
   logic [11:0] sum_ff [3];
   logic [11:0] dvd_ff [3];
   logic [3:0]  rem_ff [3];
   logic [4:0]  trial  [3];
   logic [7:0]  hist_ch [3];

   assign hist_ch[0] = hist_rd_ff[23:16];
   assign hist_ch[1] = hist_rd_ff[15:8];
   assign hist_ch[2] = hist_rd_ff[7:0];

   always_comb begin
      for (int c = 0; c < 3; c++) trial[c] = {rem_ff[c], dvd_ff[c][11]};
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.sum_clear)     sum_ff[c] <= '0;
         else if (cmd.hist_acc) sum_ff[c] <= sum_ff[c] + 12'(hist_ch[c]);
         if (cmd.div_start) begin
            dvd_ff[c] <= sum_ff[c];
            rem_ff[c] <= '0;
         end else if (cmd.div_step) begin
            if (trial[c] >= 5'(n_frames)) begin
               rem_ff[c] <= 4'(trial[c] - 5'(n_frames));
               dvd_ff[c] <= {dvd_ff[c][10:0], 1'b1};
            end else begin
               rem_ff[c] <= trial[c][3:0];
               dvd_ff[c] <= {dvd_ff[c][10:0], 1'b0};
            end
         end
      end
   end

   // Scale pipeline: brightness, intensity, gamma address; floor levels
   logic [14:0] p1_ff [3];
   logic [8:0]  a_ff  [3];
   logic [15:0] p2_ff [3];
   logic [14:0] fp_ff [3];
   logic [7:0]  col_sel [3];

   always_comb begin
      for (int c = 0; c < 3; c++) col_sel[c] = blending ? dvd_ff[c][7:0] : col_in_ff[c];
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         p1_ff[c] <= 15'(col_sel[c]) * 15'(bright_ff);
         a_ff[c]  <= 9'(div100(17'(p1_ff[c])));
         p2_ff[c] <= 16'(a_ff[c]) * 16'(inten_ff[c]);
         b_ff[c]  <= sat8(div100(17'(p2_ff[c])));
         fp_ff[c] <= 15'(floor_ff[c]) * 15'd255;
         lo_ff[c] <= sat8(div100(17'(fp_ff[c])));
      end
   end

   // Status of load modes
   always_comb begin
      case (mode_ff)
         MODE_MAP:   load_bad = !idx_ok;
         MODE_GAMMA: load_bad = (lch_ff == LUT_CH_INVALID);
         default:    load_bad = 1'b0;
      endcase
   end

   // Build the result
   always_ff @(posedge clock) begin
      if (cmd.load_exec || cmd.res_err) begin
         res_status_ff <= cmd.res_err ? 1'b1 : load_bad;
         res_led_ff    <= '0;
         for (int c = 0; c < 3; c++) res_col_ff[c] <= '0;
      end else if (cmd.res_led) begin
         res_status_ff <= 1'b0;
         res_led_ff    <= map_rd_ff[8:0];
      end else if (cmd.res_pix) begin
         for (int c = 0; c < 3; c++)
            res_col_ff[c] <= (gam_rd_ff[c] < lo_ff[c]) ? lo_ff[c] : gam_rd_ff[c];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status     <= res_status_ff;
         rsp_led_number <= res_led_ff;
         rsp_red_out    <= res_col_ff[0];
         rsp_green_out  <= res_col_ff[1];
         rsp_blue_out   <= res_col_ff[2];
      end
   end

   assign stat.mode       = mode_ff;
   assign stat.map_ok     = map_ok;
   assign stat.blending   = blending;
   assign stat.n_frames   = n_frames;
   assign stat.clear_done = clear_done;

endmodule

`default_nettype wire
